// File: rtl/bbmds_pkg.sv
// ============================================================================
// bbmds_pkg
// Shared types and constants of the buck-boost mode and duty selection core:
// modes, register indexes, controller and datapath command and status words.
// ============================================================================
package bbmds_pkg;

    // Field widths
    localparam int VOLT_W  = 16;
    localparam int DEN_W   = 15;
    localparam int DUTY_W  = 32;
    localparam int PROD_W  = 48;
    localparam int NUM_W   = 50;
    localparam int Q15_W   = 16;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 3;

    // Divider geometry: 32 quotient bits, two per cycle
    localparam int DIV_QBITS      = 32;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = DIV_QBITS / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam logic signed [DUTY_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DUTY_W-1:0] INT32_MIN = 32'sh8000_0000;
    localparam logic [Q15_W-1:0]         Q15_ONE   = 16'h8000;

    // Register reset values, Q1.15
    localparam logic [15:0] RST_ENTER_DUAL  = 16'd27853;
    localparam logic [15:0] RST_DUTY_CEIL   = 16'd29491;
    localparam logic [16:0] RST_SUM_LIMIT   = 17'd58982;
    localparam logic [15:0] RST_LEAVE_DUAL  = 16'd22938;
    localparam logic [15:0] RST_FIXED_BOOST = 16'd29491;

    typedef enum logic [1:0] {
        MODE_BUCK  = 2'd0,
        MODE_BOOST = 2'd1,
        MODE_DUAL  = 2'd2
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ENTER_DUAL   = 3'd0,
        REG_DUTY_CEILING = 3'd1,
        REG_SUM_LIMIT    = 3'd2,
        REG_LEAVE_DUAL   = 3'd3,
        REG_FIXED_BOOST  = 3'd4,
        REG_INITIAL_MODE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] enter_thr;
        logic [15:0] ceiling;
        logic [16:0] sum_limit;
        logic [15:0] leave_thr;
        logic [15:0] fixed_boost;
    } cfg_t;

    // Division kinds; buck kinds write the buck duty, boost kinds the boost duty
    typedef enum logic [1:0] {
        DIV_BUCK_PLAIN       = 2'd0,
        DIV_BOOST_PLAIN      = 2'd1,
        DIV_BOOST_GIVEN_BUCK = 2'd2,
        DIV_BUCK_GIVEN_BOOST = 2'd3
    } div_kind_t;

    typedef enum logic [2:0] {
        SET_NONE     = 3'd0,
        SET_BK_ONE   = 3'd1,
        SET_BS_ONE   = 3'd2,
        SET_BK_CEIL  = 3'd3,
        SET_BS_CEIL  = 3'd4,
        SET_BS_FIXED = 3'd5,
        SET_BK_CUT   = 3'd6,
        SET_BS_CUT   = 3'd7
    } set_op_t;

    typedef struct packed {
        logic      load;
        logic      div_start;
        div_kind_t kind;
        set_op_t   set_op;
        logic      capture;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic bk_gt_enter;
        logic bs_gt_enter;
        logic bk_gt_ceil;
        logic sum_gt_limit;
        logic bs_lt_leave;
        logic bk_lt_leave;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BK_PLAIN,
        ST_BK_CHECK,
        ST_BK_DUAL,
        ST_BS_PLAIN,
        ST_BS_CHECK,
        ST_BS_DUAL,
        ST_DL_PLAIN,
        ST_DL_CHECK,
        ST_CAP_DIV,
        ST_CAP_SUM,
        ST_CAP_CUT_DIV,
        ST_CAP_LEAVE,
        ST_CAP_EXIT_DIV,
        ST_FIX_DIV,
        ST_FIX_SUM,
        ST_FIX_CUT_DIV,
        ST_FIX_LEAVE,
        ST_FIX_EXIT_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_RUN,
        DIV_FIN
    } div_state_t;

endpackage

// File: rtl/bbmds_regs.sv
// ============================================================================
// bbmds_regs
// Configuration register file; a write to the mode register also loads the
// operating mode through a one-cycle strobe.
// ============================================================================
module bbmds_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbmds_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bbmds_pkg::CFG_W-1:0]   cfg_data,
    output bbmds_pkg::cfg_t               cfg,
    output logic                          mode_load,
    output bbmds_pkg::mode_t              mode_value
);

    bbmds_pkg::cfg_t cfg_reg;
    bbmds_pkg::cfg_t cfg_next;
    logic            wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;
    assign cfg       = cfg_reg;

    // Decode the written word into the addressed register
    always_comb begin
        cfg_next  = cfg_reg;
        mode_load = 1'b0;
        if (wr_en) begin
            case (cfg_index)
                bbmds_pkg::REG_ENTER_DUAL:   cfg_next.enter_thr   = cfg_data[15:0];
                bbmds_pkg::REG_DUTY_CEILING: cfg_next.ceiling     = cfg_data[15:0];
                bbmds_pkg::REG_SUM_LIMIT:    cfg_next.sum_limit   = cfg_data[16:0];
                bbmds_pkg::REG_LEAVE_DUAL:   cfg_next.leave_thr   = cfg_data[15:0];
                bbmds_pkg::REG_FIXED_BOOST:  cfg_next.fixed_boost = cfg_data[15:0];
                bbmds_pkg::REG_INITIAL_MODE: mode_load            = 1'b1;
                default: ;
            endcase
        end
    end

    // Map mode code three onto buck
    always_comb begin
        case (cfg_data[1:0])
            bbmds_pkg::MODE_BOOST: mode_value = bbmds_pkg::MODE_BOOST;
            bbmds_pkg::MODE_DUAL:  mode_value = bbmds_pkg::MODE_DUAL;
            default:               mode_value = bbmds_pkg::MODE_BUCK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enter_thr   <= bbmds_pkg::RST_ENTER_DUAL;
            cfg_reg.ceiling     <= bbmds_pkg::RST_DUTY_CEIL;
            cfg_reg.sum_limit   <= bbmds_pkg::RST_SUM_LIMIT;
            cfg_reg.leave_thr   <= bbmds_pkg::RST_LEAVE_DUAL;
            cfg_reg.fixed_boost <= bbmds_pkg::RST_FIXED_BOOST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/bbmds_div.sv
// ============================================================================
// bbmds_div
// Signed-by-positive restoring divider, two quotient bits per cycle. The
// quotient truncates toward zero and saturates to signed 32 bits.
// ============================================================================
module bbmds_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [bbmds_pkg::NUM_W-1:0]   num,
    input  logic [bbmds_pkg::DEN_W-1:0]          den,
    output logic                                 done,
    output logic signed [bbmds_pkg::DUTY_W-1:0]  quot
);

    localparam int NW = bbmds_pkg::NUM_W;
    localparam int DW = bbmds_pkg::DEN_W;
    localparam int QW = bbmds_pkg::DIV_QBITS;
    localparam int CW = bbmds_pkg::DIV_CNT_W;

    bbmds_pkg::div_state_t state_reg, state_next;
    logic [NW-1:0]         abs_reg, abs_next;
    logic                  neg_reg, neg_next;
    logic [DW-1:0]         den_reg, den_next;
    logic                  ovf_reg, ovf_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [QW-1:0]         qr_reg, qr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic signed [bbmds_pkg::DUTY_W-1:0] quot_reg, quot_next;

    logic [DW:0]           step_t;
    logic [DW-1:0]         step_r;
    logic [QW-1:0]         step_q;

    assign done = done_reg;
    assign quot = quot_reg;

    // Two restoring steps on the partial remainder
    always_comb begin
        step_r = rem_reg;
        step_q = qr_reg;
        step_t = '0;
        for (int i = 0; i < bbmds_pkg::DIV_RADIX_BITS; i++) begin
            step_t = {step_r, step_q[QW-1]};
            step_q = {step_q[QW-2:0], 1'b0};
            if (step_t >= {1'b0, den_reg}) begin
                step_t    = step_t - {1'b0, den_reg};
                step_q[0] = 1'b1;
            end
            step_r = step_t[DW-1:0];
        end
    end

    // Sequence: take magnitude, check range, iterate, sign and saturate
    always_comb begin
        state_next = state_reg;
        abs_next   = abs_reg;
        neg_next   = neg_reg;
        den_next   = den_reg;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        qr_next    = qr_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        case (state_reg)
            bbmds_pkg::DIV_IDLE: begin
                if (start) begin
                    neg_next   = num[NW-1];
                    abs_next   = num[NW-1] ? NW'(-num) : NW'(num);
                    den_next   = den;
                    state_next = bbmds_pkg::DIV_PREP;
                end
            end
            bbmds_pkg::DIV_PREP: begin
                ovf_next   = abs_reg[NW-1:QW-1] >= {{(NW-QW+1-DW){1'b0}}, den_reg};
                rem_next   = abs_reg[QW+DW-1:QW];
                qr_next    = abs_reg[QW-1:0];
                cnt_next   = '0;
                state_next = bbmds_pkg::DIV_RUN;
            end
            bbmds_pkg::DIV_RUN: begin
                rem_next = step_r;
                qr_next  = step_q;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(bbmds_pkg::DIV_STEPS - 1)) begin
                    state_next = bbmds_pkg::DIV_FIN;
                end
            end
            bbmds_pkg::DIV_FIN: begin
                if (ovf_reg) begin
                    quot_next = neg_reg ? bbmds_pkg::INT32_MIN : bbmds_pkg::INT32_MAX;
                end else begin
                    quot_next = neg_reg ? -$signed(qr_reg) : $signed(qr_reg);
                end
                done_next  = 1'b1;
                state_next = bbmds_pkg::DIV_IDLE;
            end
            default: state_next = bbmds_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbmds_pkg::DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        abs_reg  <= abs_next;
        neg_reg  <= neg_next;
        den_reg  <= den_next;
        ovf_reg  <= ovf_next;
        rem_reg  <= rem_next;
        qr_reg   <= qr_next;
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
    end

endmodule

// File: rtl/bbmds_dp.sv
// ============================================================================
// bbmds_dp
// Duty datapath: sample registers, buck and boost duty registers, the
// numerator multiplier, the shared divider, comparisons and output format.
// ============================================================================
module bbmds_dp #(
    parameter int DUTY_FRAC_BITS = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bbmds_pkg::dp_cmd_t                  cmd,
    output bbmds_pkg::dp_status_t               status,
    input  bbmds_pkg::cfg_t                     cfg,
    input  logic signed [bbmds_pkg::VOLT_W-1:0] in_inductor,
    input  logic signed [bbmds_pkg::VOLT_W-1:0] in_input,
    input  logic signed [bbmds_pkg::VOLT_W-1:0] in_output,
    output logic [bbmds_pkg::Q15_W-1:0]         buck_pwm,
    output logic [bbmds_pkg::Q15_W-1:0]         boost_pwm
);

    localparam int DW    = bbmds_pkg::DUTY_W;
    localparam int VW    = bbmds_pkg::VOLT_W;
    localparam int NW    = bbmds_pkg::NUM_W;
    localparam int PW    = bbmds_pkg::PROD_W;
    localparam int EW    = bbmds_pkg::DEN_W;
    localparam int SH_UP = (DUTY_FRAC_BITS > 15) ? DUTY_FRAC_BITS - 15 : 0;
    localparam int SH_DN = (DUTY_FRAC_BITS < 15) ? 15 - DUTY_FRAC_BITS : 0;
    localparam logic signed [DW-1:0] ONE_D = 32'sd1 <<< DUTY_FRAC_BITS;

    // Register value in Q1.15 to internal duty scale
    function automatic logic signed [DW-1:0] from_q15(input logic [16:0] r);
        logic [DW-1:0] w;
        w = {15'd0, r};
        if (DUTY_FRAC_BITS > 15) begin
            from_q15 = $signed(w << SH_UP);
        end else begin
            from_q15 = $signed(w >> SH_DN);
        end
    endfunction

    // Clamp to 0..1 and convert to Q1.15
    function automatic logic [bbmds_pkg::Q15_W-1:0] to_q15(input logic signed [DW-1:0] d);
        logic [DW-1:0] w;
        logic [DW-1:0] t;
        if (d < 0) begin
            w = '0;
        end else if (d > ONE_D) begin
            w = ONE_D;
        end else begin
            w = d;
        end
        t = (DUTY_FRAC_BITS > 15) ? (w >> SH_UP) : (w << SH_DN);
        to_q15 = t[bbmds_pkg::Q15_W-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat33(input logic signed [DW:0] v);
        if (v[DW] != v[DW-1]) begin
            sat33 = v[DW] ? bbmds_pkg::INT32_MIN : bbmds_pkg::INT32_MAX;
        end else begin
            sat33 = v[DW-1:0];
        end
    endfunction

    logic signed [VW-1:0]   vl_reg;
    logic [EW-1:0]          vi_reg, vo_reg;
    logic signed [DW-1:0]   bk_reg, bk_next;
    logic signed [DW-1:0]   bs_reg, bs_next;
    bbmds_pkg::div_kind_t   kind_reg;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [NW-1:0]   num_reg, num_next;
    logic                   mul_vld_reg, num_vld_reg;
    logic [bbmds_pkg::Q15_W-1:0] buck_pwm_reg, boost_pwm_reg;

    logic                   issue_buck, kind_buck;
    logic signed [VW-1:0]   x_sel;
    logic signed [DW-1:0]   m_sel;
    logic signed [NW-1:0]   vl_wide, vl_term;
    logic [EW-1:0]          den_sel;
    logic                   div_done;
    logic signed [DW-1:0]   div_quot;

    logic signed [DW-1:0]   enter_d, ceil_d, lim_d, leave_d, fixed_d;
    logic signed [DW-1:0]   sum_d, bk_cut, bs_cut;

    assign enter_d = from_q15({1'b0, cfg.enter_thr});
    assign ceil_d  = from_q15({1'b0, cfg.ceiling});
    assign lim_d   = from_q15(cfg.sum_limit);
    assign leave_d = from_q15({1'b0, cfg.leave_thr});
    assign fixed_d = from_q15({1'b0, cfg.fixed_boost});

    // Buck kinds divide by input voltage, boost kinds by output voltage
    assign issue_buck = (cmd.kind == bbmds_pkg::DIV_BUCK_PLAIN) ||
                        (cmd.kind == bbmds_pkg::DIV_BUCK_GIVEN_BOOST);
    assign kind_buck  = (kind_reg == bbmds_pkg::DIV_BUCK_PLAIN) ||
                        (kind_reg == bbmds_pkg::DIV_BUCK_GIVEN_BOOST);

    // Product term of the numerator
    always_comb begin
        x_sel = issue_buck ? $signed({1'b0, vo_reg}) : $signed({1'b0, vi_reg});
        case (cmd.kind)
            bbmds_pkg::DIV_BOOST_GIVEN_BUCK: m_sel = bk_reg;
            bbmds_pkg::DIV_BUCK_GIVEN_BOOST: m_sel = bs_reg;
            default:                         m_sel = ONE_D;
        endcase
        prod_next = x_sel * m_sel;
    end

    // Add or remove the inductor term
    assign vl_wide = {{(NW-VW){vl_reg[VW-1]}}, vl_reg};
    assign vl_term = vl_wide <<< DUTY_FRAC_BITS;
    assign num_next = kind_buck ? ({{(NW-PW){prod_reg[PW-1]}}, prod_reg} + vl_term)
                                : ({{(NW-PW){prod_reg[PW-1]}}, prod_reg} - vl_term);
    assign den_sel  = kind_buck ? vi_reg : vo_reg;

    bbmds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (num_vld_reg),
        .num     (num_reg),
        .den     (den_sel),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Saturated sum and cut-back values
    assign sum_d  = sat33({bk_reg[DW-1], bk_reg} + {bs_reg[DW-1], bs_reg});
    assign bk_cut = sat33({lim_d[DW-1], lim_d} - {bs_reg[DW-1], bs_reg});
    assign bs_cut = sat33({lim_d[DW-1], lim_d} - {bk_reg[DW-1], bk_reg});

    // Update the duty registers
    always_comb begin
        bk_next = bk_reg;
        bs_next = bs_reg;
        if (div_done) begin
            if (kind_buck) begin
                bk_next = div_quot;
            end else begin
                bs_next = div_quot;
            end
        end else begin
            case (cmd.set_op)
                bbmds_pkg::SET_BK_ONE:   bk_next = ONE_D;
                bbmds_pkg::SET_BS_ONE:   bs_next = ONE_D;
                bbmds_pkg::SET_BK_CEIL:  bk_next = ceil_d;
                bbmds_pkg::SET_BS_CEIL:  bs_next = ceil_d;
                bbmds_pkg::SET_BS_FIXED: bs_next = fixed_d;
                bbmds_pkg::SET_BK_CUT:   bk_next = bk_cut;
                bbmds_pkg::SET_BS_CUT:   bs_next = bs_cut;
                default: ;
            endcase
        end
    end

    // Report decisions to the controller
    always_comb begin
        status.div_done     = div_done;
        status.bk_gt_enter  = bk_reg > enter_d;
        status.bs_gt_enter  = bs_reg > enter_d;
        status.bk_gt_ceil   = bk_reg > ceil_d;
        status.sum_gt_limit = sum_d > lim_d;
        status.bs_lt_leave  = bs_reg < leave_d;
        status.bk_lt_leave  = bk_reg < leave_d;
    end

    assign buck_pwm  = buck_pwm_reg;
    assign boost_pwm = boost_pwm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            num_vld_reg <= 1'b0;
        end else begin
            mul_vld_reg <= cmd.div_start;
            num_vld_reg <= mul_vld_reg;
        end
    end

    // Floor the input and output voltages to one LSB on load
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vl_reg <= in_inductor;
            vi_reg <= (in_input < 16'sd1) ? EW'(1) : in_input[EW-1:0];
            vo_reg <= (in_output < 16'sd1) ? EW'(1) : in_output[EW-1:0];
        end
        if (cmd.div_start) begin
            kind_reg <= cmd.kind;
            prod_reg <= prod_next;
        end
        if (mul_vld_reg) begin
            num_reg <= num_next;
        end
        if (cmd.capture) begin
            buck_pwm_reg  <= to_q15(bk_reg);
            boost_pwm_reg <= to_q15(bs_reg);
        end
        bk_reg <= bk_next;
        bs_reg <= bs_next;
    end

endmodule

// File: rtl/bbmds_ctrl.sv
// ============================================================================
// bbmds_ctrl
// Step sequencer: holds the operating mode, walks the division and decision
// steps of one word and drives both handshakes.
// ============================================================================
module bbmds_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bbmds_pkg::mode_t      m_mode,
    input  logic                  mode_load,
    input  bbmds_pkg::mode_t      mode_value,
    input  bbmds_pkg::dp_status_t status,
    output bbmds_pkg::dp_cmd_t    cmd
);

    bbmds_pkg::ctrl_state_t state_reg, state_next;
    bbmds_pkg::mode_t       mode_reg, mode_next;
    bbmds_pkg::mode_t       m_mode_reg, m_mode_next;
    logic                   issued_reg, issued_next;
    logic                   m_valid_reg, m_valid_next;

    logic                   is_div;
    bbmds_pkg::div_kind_t   div_kind;
    bbmds_pkg::ctrl_state_t div_after;

    assign s_ready = (state_reg == bbmds_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_mode  = m_mode_reg;

    // Division steps: kind and the step that follows
    always_comb begin
        is_div    = 1'b1;
        div_kind  = bbmds_pkg::DIV_BUCK_PLAIN;
        div_after = bbmds_pkg::ST_OUT;
        case (state_reg)
            bbmds_pkg::ST_BK_PLAIN: begin
                div_kind  = bbmds_pkg::DIV_BUCK_PLAIN;
                div_after = bbmds_pkg::ST_BK_CHECK;
            end
            bbmds_pkg::ST_BK_DUAL: begin
                div_kind  = bbmds_pkg::DIV_BUCK_GIVEN_BOOST;
            end
            bbmds_pkg::ST_BS_PLAIN: begin
                div_kind  = bbmds_pkg::DIV_BOOST_PLAIN;
                div_after = bbmds_pkg::ST_BS_CHECK;
            end
            bbmds_pkg::ST_BS_DUAL: begin
                div_kind  = bbmds_pkg::DIV_BOOST_GIVEN_BUCK;
            end
            bbmds_pkg::ST_DL_PLAIN: begin
                div_kind  = bbmds_pkg::DIV_BUCK_PLAIN;
                div_after = bbmds_pkg::ST_DL_CHECK;
            end
            bbmds_pkg::ST_CAP_DIV: begin
                div_kind  = bbmds_pkg::DIV_BOOST_GIVEN_BUCK;
                div_after = bbmds_pkg::ST_CAP_SUM;
            end
            bbmds_pkg::ST_CAP_CUT_DIV: begin
                div_kind  = bbmds_pkg::DIV_BOOST_GIVEN_BUCK;
                div_after = bbmds_pkg::ST_CAP_LEAVE;
            end
            bbmds_pkg::ST_CAP_EXIT_DIV: begin
                div_kind  = bbmds_pkg::DIV_BOOST_PLAIN;
            end
            bbmds_pkg::ST_FIX_DIV: begin
                div_kind  = bbmds_pkg::DIV_BUCK_GIVEN_BOOST;
                div_after = bbmds_pkg::ST_FIX_SUM;
            end
            bbmds_pkg::ST_FIX_CUT_DIV: begin
                div_kind  = bbmds_pkg::DIV_BUCK_GIVEN_BOOST;
                div_after = bbmds_pkg::ST_FIX_LEAVE;
            end
            bbmds_pkg::ST_FIX_EXIT_DIV: begin
                div_kind  = bbmds_pkg::DIV_BUCK_PLAIN;
            end
            default: is_div = 1'b0;
        endcase
    end

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        m_mode_next  = m_mode_reg;
        issued_next  = issued_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.kind      = div_kind;
        cmd.set_op    = bbmds_pkg::SET_NONE;
        cmd.capture   = 1'b0;

        if (is_div) begin
            // Issue once, then wait for the quotient
            if (!issued_reg) begin
                cmd.div_start = 1'b1;
                issued_next   = 1'b1;
            end else if (status.div_done) begin
                issued_next = 1'b0;
                state_next  = div_after;
            end
        end else begin
            case (state_reg)
                bbmds_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        cmd.load = 1'b1;
                        case (mode_reg)
                            bbmds_pkg::MODE_BOOST: state_next = bbmds_pkg::ST_BS_PLAIN;
                            bbmds_pkg::MODE_DUAL:  state_next = bbmds_pkg::ST_DL_PLAIN;
                            default: begin
                                mode_next  = bbmds_pkg::MODE_BUCK;
                                state_next = bbmds_pkg::ST_BK_PLAIN;
                            end
                        endcase
                    end
                end
                bbmds_pkg::ST_BK_CHECK: begin
                    if (status.bk_gt_enter) begin
                        cmd.set_op = bbmds_pkg::SET_BS_CEIL;
                        mode_next  = bbmds_pkg::MODE_DUAL;
                        state_next = bbmds_pkg::ST_BK_DUAL;
                    end else begin
                        cmd.set_op = bbmds_pkg::SET_BS_ONE;
                        state_next = bbmds_pkg::ST_OUT;
                    end
                end
                bbmds_pkg::ST_BS_CHECK: begin
                    if (status.bs_gt_enter) begin
                        cmd.set_op = bbmds_pkg::SET_BK_CEIL;
                        mode_next  = bbmds_pkg::MODE_DUAL;
                        state_next = bbmds_pkg::ST_BS_DUAL;
                    end else begin
                        cmd.set_op = bbmds_pkg::SET_BK_ONE;
                        state_next = bbmds_pkg::ST_OUT;
                    end
                end
                bbmds_pkg::ST_DL_CHECK: begin
                    if (status.bk_gt_ceil) begin
                        cmd.set_op = bbmds_pkg::SET_BK_CEIL;
                        state_next = bbmds_pkg::ST_CAP_DIV;
                    end else begin
                        cmd.set_op = bbmds_pkg::SET_BS_FIXED;
                        state_next = bbmds_pkg::ST_FIX_DIV;
                    end
                end
                bbmds_pkg::ST_CAP_SUM: begin
                    if (status.sum_gt_limit) begin
                        cmd.set_op = bbmds_pkg::SET_BK_CUT;
                        state_next = bbmds_pkg::ST_CAP_CUT_DIV;
                    end else begin
                        state_next = bbmds_pkg::ST_CAP_LEAVE;
                    end
                end
                bbmds_pkg::ST_CAP_LEAVE: begin
                    if (status.bs_lt_leave) begin
                        cmd.set_op = bbmds_pkg::SET_BK_ONE;
                        mode_next  = bbmds_pkg::MODE_BOOST;
                        state_next = bbmds_pkg::ST_CAP_EXIT_DIV;
                    end else begin
                        state_next = bbmds_pkg::ST_OUT;
                    end
                end
                bbmds_pkg::ST_FIX_SUM: begin
                    if (status.sum_gt_limit) begin
                        cmd.set_op = bbmds_pkg::SET_BS_CUT;
                        state_next = bbmds_pkg::ST_FIX_CUT_DIV;
                    end else begin
                        state_next = bbmds_pkg::ST_FIX_LEAVE;
                    end
                end
                bbmds_pkg::ST_FIX_LEAVE: begin
                    if (status.bk_lt_leave) begin
                        cmd.set_op = bbmds_pkg::SET_BS_ONE;
                        mode_next  = bbmds_pkg::MODE_BUCK;
                        state_next = bbmds_pkg::ST_FIX_EXIT_DIV;
                    end else begin
                        state_next = bbmds_pkg::ST_OUT;
                    end
                end
                bbmds_pkg::ST_OUT: begin
                    // Hand the word to the output register once it is free
                    if (!m_valid_reg || m_ready) begin
                        cmd.capture  = 1'b1;
                        m_valid_next = 1'b1;
                        m_mode_next  = mode_reg;
                        state_next   = bbmds_pkg::ST_IDLE;
                    end
                end
                default: state_next = bbmds_pkg::ST_IDLE;
            endcase
        end

        // Mode register write from the configuration port
        if (mode_load) begin
            mode_next = mode_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbmds_pkg::ST_IDLE;
            mode_reg    <= bbmds_pkg::MODE_BUCK;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_mode_reg <= m_mode_next;
    end

endmodule

// File: rtl/buck_boost_mode_duty_select_core.sv
// ============================================================================
// buck_boost_mode_duty_select_core
// Mode selection and buck/boost duty computation for a four-switch stage.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready) takes one word of inductor, input and
//   output voltage. Output channel (m_valid/m_ready) returns one word per
//   input: buck duty, boost duty (Q1.15), half-frequency flag and the mode
//   after the step. Configuration (cfg_valid/cfg_ready, always ready) writes
//   the thresholds and loads the mode; the user must do so only while the
//   core is idle, as the core itself does not enforce this. Each word runs
//   through one to four divisions on a shared divider that yields two
//   quotient bits per cycle; a division runs through multiply, numerator,
//   range check, 16 steps and sign. The next input word is accepted only
//   after the current word has run through all of its divisions.
//   The result sits in an output register, so the next word is accepted
//   while it waits; a stalled receiver only holds the core before it would
//   overwrite that register.
//   Reset returns the thresholds to their defaults and the mode to buck,
//   and drops any word in flight.
// ============================================================================
module buck_boost_mode_duty_select_core #(
    parameter int DUTY_FRAC_BITS = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [bbmds_pkg::VOLT_W-1:0] s_inductor_voltage,
    input  logic signed [bbmds_pkg::VOLT_W-1:0] s_input_voltage,
    input  logic signed [bbmds_pkg::VOLT_W-1:0] s_output_voltage,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bbmds_pkg::Q15_W-1:0]         m_buck_pwm,
    output logic [bbmds_pkg::Q15_W-1:0]         m_boost_pwm,
    output logic                                m_half_frequency,
    output logic [1:0]                          m_mode_now,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbmds_pkg::IDX_W-1:0]         cfg_index,
    input  logic [bbmds_pkg::CFG_W-1:0]         cfg_data
);

    bbmds_pkg::cfg_t       cfg;
    logic                  mode_load;
    bbmds_pkg::mode_t      mode_value;
    bbmds_pkg::mode_t      m_mode;
    bbmds_pkg::dp_cmd_t    cmd;
    bbmds_pkg::dp_status_t status;

    bbmds_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .mode_load  (mode_load),
        .mode_value (mode_value)
    );

    bbmds_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_mode     (m_mode),
        .mode_load  (mode_load),
        .mode_value (mode_value),
        .status     (status),
        .cmd        (cmd)
    );

    bbmds_dp #(
        .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg),
        .in_inductor (s_inductor_voltage),
        .in_input    (s_input_voltage),
        .in_output   (s_output_voltage),
        .buck_pwm    (m_buck_pwm),
        .boost_pwm   (m_boost_pwm)
    );

    assign m_mode_now       = m_mode;
    assign m_half_frequency = (m_mode == bbmds_pkg::MODE_DUAL);

    // Duties never exceed 1.0
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_buck_pwm <= bbmds_pkg::Q15_ONE) &&
                    (m_boost_pwm <= bbmds_pkg::Q15_ONE))
        else $error("duty above 1.0 on output");

    // Buck mode runs the boost leg at full duty
    a_buck_boost_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mode_now == bbmds_pkg::MODE_BUCK) |->
        (m_boost_pwm == bbmds_pkg::Q15_ONE))
        else $error("boost duty not 1.0 in buck mode");

    // Boost mode runs the buck leg at full duty
    a_boost_buck_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mode_now == bbmds_pkg::MODE_BOOST) |->
        (m_buck_pwm == bbmds_pkg::Q15_ONE))
        else $error("buck duty not 1.0 in boost mode");

    // One word at a time: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in flight");

endmodule
